// ----- hdl/cmpf_pkg.sv -----
// Shared types and the fixed word table for the case-folding multi-word filter.
package cmpf_pkg;

   localparam int TABLE_ROWS = 32;
   localparam int TABLE_COLS = 8;
   localparam int HIT_WORD_WIDTH = 4;

   localparam logic [7:0] UPPER_FIRST = 8'hC0;
   localparam logic [7:0] UPPER_LAST = 8'hDF;
   localparam logic [7:0] CASE_OFFSET = 8'h20;
   localparam logic [7:0] UPPER_YO = 8'hA8;
   localparam logic [7:0] LOWER_YO = 8'hB8;
   localparam logic [7:0] LOWER_YE = 8'hE5;

   typedef logic [7:0] word_row_type [TABLE_COLS];

   localparam word_row_type WORD_TABLE [TABLE_ROWS] = '{
      0:  '{8'hE1, 8'hEB, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      1:  '{8'hF1, 8'hF3, 8'hEA, 8'hE0, 8'h00, 8'h00, 8'h00, 8'h00},
      2:  '{8'hEF, 8'hE8, 8'hE7, 8'hE4, 8'h00, 8'h00, 8'h00, 8'h00},
      3:  '{8'hF5, 8'hF3, 8'hE9, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      4:  '{8'hF5, 8'hF3, 8'hE5, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      5:  '{8'hE5, 8'hE1, 8'hE0, 8'hED, 8'h00, 8'h00, 8'h00, 8'h00},
      6:  '{8'hE6, 8'hEE, 8'hEF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      7:  '{8'hF5, 8'hE5, 8'hF0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      8:  '{8'hE3, 8'hE0, 8'hE4, 8'hE8, 8'hED, 8'h00, 8'h00, 8'h00},
      9:  '{8'hF1, 8'hEF, 8'hE6, 8'hF0, 8'hEC, 8'h00, 8'h00, 8'h00},
      10: '{8'hF2, 8'hF0, 8'hE0, 8'hF5, 8'h00, 8'h00, 8'h00, 8'h00},
      11: '{8'hEC, 8'hE8, 8'hED, 8'hE5, 8'hF2, 8'h00, 8'h00, 8'h00},
      default: '{default: 8'h00}
   };

   localparam logic [3:0] WORD_LEN [TABLE_ROWS] = '{
      0: 4'd3, 1: 4'd4, 2: 4'd4, 3: 4'd3, 4: 4'd3, 5: 4'd4,
      6: 4'd3, 7: 4'd3, 8: 4'd5, 9: 4'd5, 10: 4'd4, 11: 4'd5,
      default: 4'd0
   };

   typedef struct packed {
      logic                      hit;
      logic [HIT_WORD_WIDTH-1:0] hit_word;
      logic                      seen_any;
      logic                      verdict_ready;
      logic                      clean;
   } match_result_type;

endpackage

// ----- hdl/cmpf_fold.sv -----
// Lowercase folding of one single-byte Cyrillic code-page character; both forms of yo fold to ye.
module cmpf_fold import cmpf_pkg::*; (
   input  logic [7:0] raw_byte,
   output logic [7:0] folded_byte
);

   always_comb begin
      folded_byte = raw_byte;
      if (raw_byte >= UPPER_FIRST && raw_byte <= UPPER_LAST) begin
         folded_byte = raw_byte + CASE_OFFSET;
      end
      if (raw_byte == UPPER_YO || raw_byte == LOWER_YO) begin
         folded_byte = LOWER_YE;
      end
   end

endmodule

// ----- hdl/cmpf_match.sv -----
// Folded-byte history window, parallel word comparators and sticky match flag.
module cmpf_match import cmpf_pkg::*; #(
   parameter int WORD_COUNT = 12,
   parameter int MAX_WORD_LEN = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic [7:0]       cur_byte,
   input  logic             end_of_text,
   output match_result_type result
);

   localparam int HistDepth = MAX_WORD_LEN - 1;

   logic [7:0] hist_ff [HistDepth];
   logic       seen_ff;
   logic [7:0] win [MAX_WORD_LEN];
   logic [WORD_COUNT-1:0] word_hit;
   logic       any_hit;
   logic       seen_in;

   always_comb begin
      win[0] = cur_byte;
      for (int k = 1; k < MAX_WORD_LEN; k++) begin
         win[k] = hist_ff[k-1];
      end
   end

   for (genvar w = 0; w < WORD_COUNT; w++) begin : g_word
      localparam int Len = int'(WORD_LEN[w]);
      if (Len == 0 || Len > MAX_WORD_LEN) begin : g_never
         assign word_hit[w] = 1'b0;
      end else begin : g_cmp
         logic [Len-1:0] eq;
         for (genvar k = 0; k < Len; k++) begin : g_pos
            assign eq[k] = (WORD_TABLE[w][Len-1-k] == win[k]);
         end
         assign word_hit[w] = &eq;
      end
   end

   always_comb begin
      result.hit_word = '0;
      for (int w = WORD_COUNT - 1; w >= 0; w--) begin
         if (word_hit[w]) begin
            result.hit_word = HIT_WORD_WIDTH'(w);
         end
      end
      any_hit = |word_hit;
      seen_in = seen_ff | any_hit;
      result.hit = any_hit;
      result.seen_any = seen_in;
      result.verdict_ready = end_of_text;
      result.clean = end_of_text & ~seen_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
         for (int k = 0; k < HistDepth; k++) begin
            hist_ff[k] <= 8'h00;
         end
      end else if (advance) begin
         if (end_of_text) begin
            seen_ff <= 1'b0;
            for (int k = 0; k < HistDepth; k++) begin
               hist_ff[k] <= 8'h00;
            end
         end else begin
            seen_ff <= seen_in;
            hist_ff[0] <= cur_byte;
            for (int k = 1; k < HistDepth; k++) begin
               hist_ff[k] <= hist_ff[k-1];
            end
         end
      end
   end

endmodule

// ----- hdl/casefold_multi_pattern_filter_unit.sv -----
// Top level of the case-insensitive multi-word filter over a byte stream.
// A byte is folded into the input register, and its match result is then held in the result register.
// Throughput: one byte per cycle while rsp_stall is low; the input register and the result register
// form a two-stage pipeline, so a new byte can enter while a result waits.
// Reset clears both stage valid flags, the folded-byte window and the sticky flag.
module casefold_multi_pattern_filter_unit import cmpf_pkg::*; #(
   parameter int WORD_COUNT = 12,
   parameter int MAX_WORD_LEN = 5
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [7:0]                req_text_byte,
   input  logic                      req_end_of_text,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_hit,
   output logic [HIT_WORD_WIDTH-1:0] rsp_hit_word,
   output logic                      rsp_seen_any,
   output logic                      rsp_verdict_ready,
   output logic                      rsp_clean
);

   logic             s1_valid_ff;
   logic             s1_valid_in;
   logic [7:0]       s1_byte_ff;
   logic             s1_eot_ff;
   logic             s1_advance;
   logic             req_take;
   logic [7:0]       folded;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   match_result_type rsp_data_ff;
   match_result_type match_out;

   cmpf_fold u_fold (
      .raw_byte    (req_text_byte),
      .folded_byte (folded)
   );

   cmpf_match #(
      .WORD_COUNT   (WORD_COUNT),
      .MAX_WORD_LEN (MAX_WORD_LEN)
   ) u_match (
      .clock       (clock),
      .reset       (reset),
      .advance     (s1_advance),
      .cur_byte    (s1_byte_ff),
      .end_of_text (s1_eot_ff),
      .result      (match_out)
   );

   assign s1_advance = s1_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall = s1_valid_ff & ~s1_advance;
   assign req_take = req_valid & ~req_stall;
   assign s1_valid_in = req_take | (s1_valid_ff & ~s1_advance);
   assign rsp_valid_in = s1_advance | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff <= folded;
         s1_eot_ff <= req_end_of_text;
      end
      if (s1_advance) begin
         rsp_data_ff <= match_out;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit = rsp_data_ff.hit;
   assign rsp_hit_word = rsp_data_ff.hit_word;
   assign rsp_seen_any = rsp_data_ff.seen_any;
   assign rsp_verdict_ready = rsp_data_ff.verdict_ready;
   assign rsp_clean = rsp_data_ff.clean;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> rsp_seen_any && !rsp_clean)
      else $error("A hit must set the sticky flag and rule out a clean verdict.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_hit_word == '0)
      else $error("The word index must be zero when no word matched.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clean |-> rsp_verdict_ready)
      else $error("A clean verdict may only appear on the final byte.");

   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && rsp_valid_ff && rsp_stall)
      else $error("The input side stalled while the pipeline could move.");

endmodule

// ----- dv/casefold_multi_pattern_filter_unit_tb.sv -----
// Self-checking testbench for the case-insensitive multi-word filter.
module casefold_multi_pattern_filter_unit_tb import cmpf_pkg::*; ();

   localparam int QUIET_LIMIT = 5000;
   localparam int RANDOM_TARGET = 1175;

   localparam logic [7:0] LEXICON [12][5] = '{
      '{8'hE1, 8'hEB, 8'hFF, 8'h00, 8'h00},
      '{8'hF1, 8'hF3, 8'hEA, 8'hE0, 8'h00},
      '{8'hEF, 8'hE8, 8'hE7, 8'hE4, 8'h00},
      '{8'hF5, 8'hF3, 8'hE9, 8'h00, 8'h00},
      '{8'hF5, 8'hF3, 8'hE5, 8'h00, 8'h00},
      '{8'hE5, 8'hE1, 8'hE0, 8'hED, 8'h00},
      '{8'hE6, 8'hEE, 8'hEF, 8'h00, 8'h00},
      '{8'hF5, 8'hE5, 8'hF0, 8'h00, 8'h00},
      '{8'hE3, 8'hE0, 8'hE4, 8'hE8, 8'hED},
      '{8'hF1, 8'hEF, 8'hE6, 8'hF0, 8'hEC},
      '{8'hF2, 8'hF0, 8'hE0, 8'hF5, 8'h00},
      '{8'hEC, 8'hE8, 8'hED, 8'hE5, 8'hF2}
   };
   localparam int LEXICON_LEN [12] = '{3, 4, 4, 3, 3, 4, 3, 3, 5, 5, 4, 5};

   // Each entry is {end_of_text, text_byte}.
   localparam logic [8:0] OPENING_TEXT [24] = '{
      9'h000, 9'h1FF,
      9'h0C1, 9'h0CB, 9'h0DF, 9'h100,
      9'h0F5, 9'h0D3, 9'h0A8, 9'h0F5, 9'h0F3, 9'h1E9,
      9'h0F5, 9'h1F3,
      9'h0E9, 9'h0B8, 9'h0C1, 9'h0C0, 9'h1CD,
      9'h0CC, 9'h0C8, 9'h0CD, 9'h0C5, 9'h1D2
   };

   typedef struct {
      logic [7:0] text_byte;
      logic       end_of_text;
      bit         drain_before;
   } text_item_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [7:0]                req_text_byte = 8'h00;
   logic                      req_end_of_text = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_hit;
   logic [HIT_WORD_WIDTH-1:0] rsp_hit_word;
   logic                      rsp_seen_any;
   logic                      rsp_verdict_ready;
   logic                      rsp_clean;

   text_item_type    bytes_to_send[$];
   match_result_type expected_scans[$];
   logic [7:0]       draft_text[$];
   logic [7:0]       recent_letters [4] = '{default: 8'h00};
   bit               sticky_match = 1'b0;
   int               bytes_accepted = 0;
   int               total_bytes = 1;
   int               error_count = 0;
   int               quiet_cycles = 0;
   bit               byte_taken;
   text_item_type    next_item;
   match_result_type wanted;

   casefold_multi_pattern_filter_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_text_byte(req_text_byte),
      .req_end_of_text(req_end_of_text),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_hit(rsp_hit),
      .rsp_hit_word(rsp_hit_word),
      .rsp_seen_any(rsp_seen_any),
      .rsp_verdict_ready(rsp_verdict_ready),
      .rsp_clean(rsp_clean)
   );

   always #5 clock = ~clock;

   function automatic logic [7:0] fold_case(input logic [7:0] c);
      if (c >= 8'hC0 && c <= 8'hDF) return c + 8'h20;
      if (c == 8'hA8 || c == 8'hB8) return 8'hE5;
      return c;
   endfunction

   function automatic match_result_type scan_byte(input logic [7:0] raw, input logic last);
      match_result_type r;
      logic [7:0]       window [5];
      bit               same;
      window[0] = fold_case(raw);
      for (int k = 1; k < 5; k++) window[k] = recent_letters[k-1];
      r = '0;
      for (int w = 0; w < 12 && !r.hit; w++) begin
         same = 1'b1;
         for (int k = 0; k < LEXICON_LEN[w]; k++) begin
            if (LEXICON[w][LEXICON_LEN[w]-1-k] != window[k]) same = 1'b0;
         end
         if (same) begin
            r.hit = 1'b1;
            r.hit_word = HIT_WORD_WIDTH'(w);
         end
      end
      if (r.hit) sticky_match = 1'b1;
      r.seen_any = sticky_match;
      r.verdict_ready = last;
      r.clean = last && !sticky_match;
      if (last) begin
         recent_letters = '{default: 8'h00};
         sticky_match = 1'b0;
      end else begin
         for (int k = 3; k > 0; k--) recent_letters[k] = recent_letters[k-1];
         recent_letters[0] = window[0];
      end
      return r;
   endfunction

   function automatic int idle_percent(input bit for_sender);
      int phase;
      phase = (bytes_accepted * 3) / total_bytes;
      if (phase == 0) return for_sender ? 18 : 78;
      if (phase == 1) return for_sender ? 78 : 18;
      return 0;
   endfunction

   function automatic logic [7:0] random_case(input logic [7:0] c);
      if (c == 8'hE5) begin
         case ($urandom_range(0, 3))
            0: return 8'hE5;
            1: return 8'hC5;
            2: return 8'hA8;
            default: return 8'hB8;
         endcase
      end
      if (c >= 8'hE0 && $urandom_range(0, 1) == 1) return c - 8'h20;
      return c;
   endfunction

   task automatic add_word(input int idx, input bit broken);
      int len;
      int spoil;
      len = LEXICON_LEN[idx];
      spoil = broken ? $urandom_range(0, len) : -1;
      for (int k = 0; k < len; k++) begin
         if (k == spoil) begin
            if ($urandom_range(0, 1) == 1) draft_text.push_back(8'($urandom_range(0, 255)));
         end else begin
            draft_text.push_back(random_case(LEXICON[idx][k]));
         end
      end
   endtask

   initial begin
      int target;
      int pick;
      foreach (OPENING_TEXT[i])
         bytes_to_send.push_back('{OPENING_TEXT[i][7:0], OPENING_TEXT[i][8], 1'b0});
      bytes_to_send.push_back('{8'hE1, 1'b0, 1'b1});
      bytes_to_send.push_back('{8'hEB, 1'b0, 1'b0});
      bytes_to_send.push_back('{8'hFF, 1'b1, 1'b0});
      while (bytes_to_send.size() < RANDOM_TARGET) begin
         target = $urandom_range(1, 24);
         draft_text.delete();
         while (draft_text.size() < target) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) add_word($urandom_range(0, 11), 1'b0);
            else if (pick < 6) add_word($urandom_range(0, 11), 1'b1);
            else if (pick < 8) draft_text.push_back(8'($urandom_range(8'hC0, 8'hFF)));
            else draft_text.push_back(8'($urandom_range(0, 255)));
         end
         foreach (draft_text[i])
            bytes_to_send.push_back('{draft_text[i], i == draft_text.size() - 1, 1'b0});
      end
      total_bytes = bytes_to_send.size();
      bytes_to_send[total_bytes / 3].drain_before = 1'b1;
      bytes_to_send[(2 * total_bytes) / 3].drain_before = 1'b1;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      while (bytes_to_send.size() != 0 || req_valid) @(posedge clock);
      while (expected_scans.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         byte_taken = req_valid && !req_stall;
         if (byte_taken) begin
            expected_scans.push_back(scan_byte(req_text_byte, req_end_of_text));
            bytes_accepted++;
         end
         if (!req_valid || byte_taken) begin
            if (bytes_to_send.size() == 0 || $urandom_range(0, 99) < idle_percent(1'b1)
                || (bytes_to_send[0].drain_before
                    && (byte_taken || expected_scans.size() != 0))) begin
               req_valid <= 1'b0;
            end else begin
               next_item = bytes_to_send.pop_front();
               req_valid <= 1'b1;
               req_text_byte <= next_item.text_byte;
               req_end_of_text <= next_item.end_of_text;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= $urandom_range(0, 99) < idle_percent(1'b0);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_scans.size() == 0) begin
            $error("result transaction with no byte outstanding");
            error_count++;
         end else begin
            wanted = expected_scans.pop_front();
            if (rsp_hit !== wanted.hit) begin
               $error("hit: expected %0d, got %0d", wanted.hit, rsp_hit);
               error_count++;
            end
            if (rsp_hit_word !== wanted.hit_word) begin
               $error("hit_word: expected %0d, got %0d", wanted.hit_word, rsp_hit_word);
               error_count++;
            end
            if (rsp_seen_any !== wanted.seen_any) begin
               $error("seen_any: expected %0d, got %0d", wanted.seen_any, rsp_seen_any);
               error_count++;
            end
            if (rsp_verdict_ready !== wanted.verdict_ready) begin
               $error("verdict_ready: expected %0d, got %0d",
                      wanted.verdict_ready, rsp_verdict_ready);
               error_count++;
            end
            if (rsp_clean !== wanted.clean) begin
               $error("clean: expected %0d, got %0d", wanted.clean, rsp_clean);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

endmodule

// ----- casefold_multi_pattern_filter_unit.f -----
hdl/cmpf_pkg.sv
hdl/cmpf_fold.sv
hdl/cmpf_match.sv
hdl/casefold_multi_pattern_filter_unit.sv
dv/casefold_multi_pattern_filter_unit_tb.sv
